// ===== src/mlfq_pkg.sv =====
`timescale 1ns / 1ps

package mlfq_pkg;

   localparam int MAX_JOBS_DEF = 64;
   localparam int LEVELS_DEF   = 3;
   localparam int LVW          = 2;
   localparam int DW           = 16;
   localparam int CSR_IW       = 3;

   localparam logic [1:0]    LEVEL_COUNT_RST  = 2'd3;
   localparam logic [DW-1:0] BOOST_PERIOD_RST = 16'd100;

   localparam logic [CSR_IW-1:0] CSR_LEVEL_COUNT  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_BOOST_PERIOD = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_QUANTUM0     = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_QUANTUM1     = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_QUANTUM2     = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_ALLOT0       = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_ALLOT1       = 3'd6;
   localparam logic [CSR_IW-1:0] CSR_ALLOT2       = 3'd7;

   localparam logic CMD_ADMIT = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   typedef struct packed {
      logic          cmd;
      logic [5:0]    new_job_id;
      logic [DW-1:0] new_job_burst;
   } req_type;

   typedef struct packed {
      logic [31:0] tick_time;
      logic        busy_res;
      logic [5:0]  run_job_id;
      logic [1:0]  run_level;
      logic        first_run;
      logic        job_done;
   } rsp_type;

   typedef struct packed {
      logic [DW-1:0]  remaining;
      logic [LVW-1:0] prio;
      logic [DW-1:0]  at_level;
      logic [DW-1:0]  slice;
      logic           started;
   } job_type;

   typedef struct packed {
      logic           push_en;
      logic [LVW-1:0] push_lv;
      logic           pop_en;
      logic [LVW-1:0] pop_lv;
   } qctl_type;

   function automatic logic [DW-1:0] sat_inc(input logic [DW-1:0] x);
      logic [DW-1:0] r;
      r = (x == {DW{1'b1}}) ? x : x + 1'b1;
      return r;
   endfunction

endpackage

// ===== src/mlfq_job_mem.sv =====
`timescale 1ns / 1ps

module mlfq_job_mem #(
   parameter int MAX_JOBS = mlfq_pkg::MAX_JOBS_DEF,
   parameter int JW       = $clog2(MAX_JOBS)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [JW-1:0]     waddr,
   input  mlfq_pkg::job_type wdata,
   input  logic [JW-1:0]     raddr,
   output mlfq_pkg::job_type rdata
);

   mlfq_pkg::job_type mem_ff [MAX_JOBS];
   mlfq_pkg::job_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/mlfq_queue.sv =====
`timescale 1ns / 1ps

module mlfq_queue #(
   parameter int MAX_JOBS = mlfq_pkg::MAX_JOBS_DEF,
   parameter int LEVELS   = mlfq_pkg::LEVELS_DEF,
   parameter int JW       = $clog2(MAX_JOBS),
   parameter int CW       = $clog2(MAX_JOBS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mlfq_pkg::qctl_type           ctl,
   input  logic [JW-1:0]                push_id,
   output logic [JW-1:0]                pop_id,
   output logic [LEVELS-1:0][CW-1:0]    counts
);

   localparam int QD  = LEVELS * MAX_JOBS;
   localparam int QAW = (QD > 1) ? $clog2(QD) : 1;

   logic [JW-1:0] mem_ff [QD];
   logic [JW-1:0] rd_ff;
   logic [JW-1:0] heads_ff [LEVELS];
   logic [JW-1:0] tails_ff [LEVELS];
   logic [CW-1:0] counts_ff [LEVELS];
   logic          push_ok;
   logic [QAW-1:0] waddr;
   logic [QAW-1:0] raddr;

   function automatic logic [JW-1:0] wrap_inc(input logic [JW-1:0] x);
      logic [JW-1:0] r;
      r = (x == JW'(MAX_JOBS - 1)) ? '0 : x + 1'b1;
      return r;
   endfunction

   assign push_ok = ctl.push_en && (counts_ff[ctl.push_lv] != CW'(MAX_JOBS));
   assign waddr = QAW'(ctl.push_lv) * QAW'(MAX_JOBS) + QAW'(tails_ff[ctl.push_lv]);
   assign raddr = QAW'(ctl.pop_lv) * QAW'(MAX_JOBS) + QAW'(heads_ff[ctl.pop_lv]);

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[waddr] <= push_id;
      end
      rd_ff <= mem_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            heads_ff[i]  <= '0;
            tails_ff[i]  <= '0;
            counts_ff[i] <= '0;
         end
      end else begin
         if (push_ok) begin
            tails_ff[ctl.push_lv]  <= wrap_inc(tails_ff[ctl.push_lv]);
            counts_ff[ctl.push_lv] <= counts_ff[ctl.push_lv] + 1'b1;
         end
         if (ctl.pop_en) begin
            heads_ff[ctl.pop_lv]  <= wrap_inc(heads_ff[ctl.pop_lv]);
            counts_ff[ctl.pop_lv] <= counts_ff[ctl.pop_lv] - 1'b1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         counts[i] = counts_ff[i];
      end
   end

   assign pop_id = rd_ff;

endmodule

// ===== src/mlfq_tick_scheduler.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Transaction
// req_      in         admit a job (cmd 0) or advance one tick (cmd 1)
// rsp_      out        one result per tick, none per admit
// csr_      in         register write, index and 16-bit data
//
// An admit is accepted in the idle state without stalling the input. A tick stalls
// the input while it settles the running job, checks for a boost, picks a job and
// runs it by a read-modify-write of the job memory. A boost returns every queued
// job and the running job to level 0. A waiting result holds the tick until taken.
// Reset is synchronous and clears control state; no memory is cleared.

module mlfq_tick_scheduler #(
   parameter int MAX_JOBS = mlfq_pkg::MAX_JOBS_DEF,
   parameter int LEVELS   = mlfq_pkg::LEVELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mlfq_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mlfq_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [mlfq_pkg::CSR_IW-1:0]     csr_index,
   input  logic [mlfq_pkg::DW-1:0]         csr_wdata
);

   localparam int JW  = $clog2(MAX_JOBS);
   localparam int CW  = $clog2(MAX_JOBS + 1);
   localparam int LVW = mlfq_pkg::LVW;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_SETTLE = 11'b00000000010,
      ST_BCHK   = 11'b00000000100,
      ST_BQ     = 11'b00000001000,
      ST_BJRD   = 11'b00000010000,
      ST_BJWR   = 11'b00000100000,
      ST_BRUN   = 11'b00001000000,
      ST_PICK   = 11'b00010000000,
      ST_PICK2  = 11'b00100000000,
      ST_RUN    = 11'b01000000000,
      ST_OUT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]              level_count_ff;
   logic [mlfq_pkg::DW-1:0] boost_period_ff;
   logic [mlfq_pkg::DW-1:0] quantum_ff [3];
   logic [mlfq_pkg::DW-1:0] allot_ff [3];

   logic          running_valid_ff, running_valid_in;
   logic [JW-1:0] running_job_ff, running_job_in;
   logic          pending_ff, pending_in;
   logic [31:0]   now_ff, now_in;
   logic [31:0]   boost_mark_ff, boost_mark_in;
   logic [LVW-1:0] lvl_ff, lvl_in;
   logic [JW-1:0] bid_ff, bid_in;
   mlfq_pkg::rsp_type res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   mlfq_pkg::rsp_type rsp_ff;

   logic              jm_we;
   logic [JW-1:0]     jm_waddr;
   mlfq_pkg::job_type jm_wdata;
   logic [JW-1:0]     jm_raddr;
   mlfq_pkg::job_type jm_rd;

   mlfq_pkg::qctl_type       qctl;
   logic [JW-1:0]            q_push_id;
   logic [JW-1:0]            q_pop_id;
   logic [LEVELS-1:0][CW-1:0] q_counts;

   logic          req_fire;
   logic          rsp_load;
   logic [JW-1:0] adm_id;
   logic          adm_ok;
   logic [LVW-1:0] active;
   logic [LVW-1:0] cur_lv;
   logic [mlfq_pkg::DW-1:0] cur_a;
   logic [mlfq_pkg::DW-1:0] cur_q;
   logic          higher_busy;
   logic          any_queued;
   logic [LVW-1:0] first_lv;
   logic          boost_due;
   mlfq_pkg::job_type run_job;

   mlfq_job_mem #(.MAX_JOBS(MAX_JOBS), .JW(JW)) u_job_mem (
      .clock (clock),
      .we    (jm_we),
      .waddr (jm_waddr),
      .wdata (jm_wdata),
      .raddr (jm_raddr),
      .rdata (jm_rd)
   );

   mlfq_queue #(.MAX_JOBS(MAX_JOBS), .LEVELS(LEVELS), .JW(JW), .CW(CW)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl     (qctl),
      .push_id (q_push_id),
      .pop_id  (q_pop_id),
      .counts  (q_counts)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign adm_id = JW'(req_data.new_job_id);
   assign adm_ok = ({5'd0, req_data.new_job_id} < 11'(MAX_JOBS)) &&
                   (req_data.new_job_burst != '0);

   assign active = (level_count_ff == 2'd0) ? 2'd1 :
                   (level_count_ff > LVW'(LEVELS)) ? LVW'(LEVELS) : level_count_ff;
   assign cur_lv = jm_rd.prio;
   assign cur_a  = allot_ff[cur_lv];
   assign cur_q  = quantum_ff[cur_lv];
   assign boost_due = (now_ff - boost_mark_ff) >= {16'd0, boost_period_ff};

   always_comb begin
      higher_busy = 1'b0;
      any_queued  = 1'b0;
      first_lv    = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (q_counts[i] != '0) begin
            any_queued = 1'b1;
            first_lv   = LVW'(i);
            if (LVW'(i) < cur_lv) begin
               higher_busy = 1'b1;
            end
         end
      end
   end

   always_comb begin
      run_job          = jm_rd;
      run_job.started  = 1'b1;
      run_job.remaining = (jm_rd.remaining != '0) ? jm_rd.remaining - 1'b1 : jm_rd.remaining;
      run_job.at_level = mlfq_pkg::sat_inc(jm_rd.at_level);
      run_job.slice    = mlfq_pkg::sat_inc(jm_rd.slice);
   end

   always_comb begin
      state_in         = state_ff;
      running_valid_in = running_valid_ff;
      running_job_in   = running_job_ff;
      pending_in       = pending_ff;
      now_in           = now_ff;
      boost_mark_in    = boost_mark_ff;
      lvl_in           = lvl_ff;
      bid_in           = bid_ff;
      res_in           = res_ff;
      jm_we            = 1'b0;
      jm_waddr         = running_job_ff;
      jm_wdata         = jm_rd;
      jm_raddr         = running_job_ff;
      qctl             = '0;
      q_push_id        = running_job_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.cmd == mlfq_pkg::CMD_ADMIT) begin
                  if (adm_ok) begin
                     jm_we    = 1'b1;
                     jm_waddr = adm_id;
                     jm_wdata = '{remaining: req_data.new_job_burst, prio: '0,
                                  at_level: '0, slice: '0, started: 1'b0};
                     qctl.push_en = 1'b1;
                     qctl.push_lv = '0;
                     q_push_id    = adm_id;
                  end
               end else if (pending_ff && running_valid_ff) begin
                  state_in = ST_SETTLE;
               end else begin
                  pending_in = 1'b0;
                  state_in   = ST_BCHK;
               end
            end
         end
         ST_SETTLE: begin
            pending_in = 1'b0;
            state_in   = ST_BCHK;
            if (jm_rd.remaining == '0) begin
               running_valid_in = 1'b0;
            end else if (cur_a != '0 && jm_rd.at_level >= cur_a) begin
               jm_we           = 1'b1;
               jm_wdata.prio   = (cur_lv + 1'b1 < active) ? cur_lv + 1'b1 : cur_lv;
               jm_wdata.at_level = '0;
               jm_wdata.slice  = '0;
               qctl.push_en    = 1'b1;
               qctl.push_lv    = jm_wdata.prio;
               running_valid_in = 1'b0;
            end else if (higher_busy) begin
               qctl.push_en    = 1'b1;
               qctl.push_lv    = cur_lv;
               running_valid_in = 1'b0;
            end else if (cur_q != '0 && jm_rd.slice >= cur_q) begin
               jm_we           = 1'b1;
               jm_wdata.slice  = '0;
               qctl.push_en    = 1'b1;
               qctl.push_lv    = cur_lv;
               running_valid_in = 1'b0;
            end
         end
         ST_BCHK: begin
            if (boost_due) begin
               lvl_in   = 2'd1;
               state_in = ST_BQ;
            end else begin
               state_in = ST_PICK;
            end
         end
         ST_BQ: begin
            if (lvl_ff >= LVW'(LEVELS)) begin
               boost_mark_in = now_ff;
               state_in = running_valid_ff ? ST_BRUN : ST_PICK;
            end else if (q_counts[lvl_ff] == '0) begin
               lvl_in = lvl_ff + 1'b1;
            end else begin
               qctl.pop_en = 1'b1;
               qctl.pop_lv = lvl_ff;
               state_in    = ST_BJRD;
            end
         end
         ST_BJRD: begin
            bid_in   = q_pop_id;
            jm_raddr = q_pop_id;
            state_in = ST_BJWR;
         end
         ST_BJWR: begin
            jm_we    = 1'b1;
            jm_waddr = bid_ff;
            jm_wdata.prio     = '0;
            jm_wdata.at_level = '0;
            jm_wdata.slice    = '0;
            qctl.push_en = 1'b1;
            qctl.push_lv = '0;
            q_push_id    = bid_ff;
            state_in     = ST_BQ;
         end
         ST_BRUN: begin
            if (jm_rd.prio != '0) begin
               jm_we = 1'b1;
               jm_wdata.prio     = '0;
               jm_wdata.at_level = '0;
               jm_wdata.slice    = '0;
            end
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (running_valid_ff) begin
               state_in = ST_RUN;
            end else if (any_queued) begin
               qctl.pop_en = 1'b1;
               qctl.pop_lv = first_lv;
               state_in    = ST_PICK2;
            end else begin
               res_in           = '0;
               res_in.tick_time = now_ff;
               now_in           = now_ff + 1'b1;
               state_in         = ST_OUT;
            end
         end
         ST_PICK2: begin
            running_job_in   = q_pop_id;
            running_valid_in = 1'b1;
            jm_raddr         = q_pop_id;
            state_in         = ST_RUN;
         end
         ST_RUN: begin
            jm_we    = 1'b1;
            jm_wdata = run_job;
            res_in.tick_time  = now_ff;
            res_in.busy_res   = 1'b1;
            res_in.run_job_id = 6'(running_job_ff);
            res_in.run_level  = jm_rd.prio;
            res_in.first_run  = !jm_rd.started;
            res_in.job_done   = (run_job.remaining == '0);
            now_in            = now_ff + 1'b1;
            pending_in        = 1'b1;
            state_in          = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         running_valid_ff <= 1'b0;
         running_job_ff   <= '0;
         pending_ff       <= 1'b0;
         now_ff           <= '0;
         boost_mark_ff    <= '0;
         lvl_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         running_valid_ff <= running_valid_in;
         running_job_ff   <= running_job_in;
         pending_ff       <= pending_in;
         now_ff           <= now_in;
         boost_mark_ff    <= boost_mark_in;
         lvl_ff           <= lvl_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bid_ff <= bid_in;
      res_ff <= res_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff  <= mlfq_pkg::LEVEL_COUNT_RST;
         boost_period_ff <= mlfq_pkg::BOOST_PERIOD_RST;
         for (int i = 0; i < 3; i++) begin
            quantum_ff[i] <= '0;
            allot_ff[i]   <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            mlfq_pkg::CSR_LEVEL_COUNT:  level_count_ff  <= csr_wdata[1:0];
            mlfq_pkg::CSR_BOOST_PERIOD: boost_period_ff <= csr_wdata;
            mlfq_pkg::CSR_QUANTUM0:     quantum_ff[0]   <= csr_wdata;
            mlfq_pkg::CSR_QUANTUM1:     quantum_ff[1]   <= csr_wdata;
            mlfq_pkg::CSR_QUANTUM2:     quantum_ff[2]   <= csr_wdata;
            mlfq_pkg::CSR_ALLOT0:       allot_ff[0]     <= csr_wdata;
            mlfq_pkg::CSR_ALLOT1:       allot_ff[1]     <= csr_wdata;
            mlfq_pkg::CSR_ALLOT2:       allot_ff[2]     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/mlfq_chk.sv =====
`timescale 1ns / 1ps

module mlfq_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mlfq_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mlfq_pkg::rsp_type rsp_data
);

   // A waiting result stays until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A tick transaction keeps the input side stalled while it is worked.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.cmd == mlfq_pkg::CMD_TICK |=> req_stall)
      else $error("tick accepted without stalling the input");

   // An admit never produces a result.
   a_admit_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.cmd == mlfq_pkg::CMD_ADMIT && !rsp_valid
      |=> !rsp_valid)
      else $error("result after an admit");

   // An idle tick reports no job.
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_res |->
         rsp_data.run_job_id == 6'd0 && !rsp_data.first_run && !rsp_data.job_done)
      else $error("idle tick with job fields set");

endmodule

bind mlfq_tick_scheduler mlfq_chk u_mlfq_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
